@@ src/reservoir_sampler_defines.svh @@
// Assertion macros for the reservoir sampler.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef RESERVOIR_SAMPLER_DEFINES_SVH
`define RESERVOIR_SAMPLER_DEFINES_SVH

`ifndef SYNTHESIS
`define RS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("reservoir sampler check failed");
`define RS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("reservoir sampler check failed");
`else
`define RS_ASSERT(lbl, clk, rst_n, prop)
`define RS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

@@ src/rs_pkg.sv @@
// Shared constants, types and helpers for the reservoir sampler.
// No dependencies.
package rs_pkg;

  localparam int DEPTH  = 128;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SIZE_W = $clog2(DEPTH + 1);
  localparam int SEEN_W = 31;
  localparam int RND_W  = 32;
  localparam int SMP_W  = 64;

  localparam logic [SEEN_W-1:0] SEEN_MAX   = {SEEN_W{1'b1}};
  localparam logic [7:0]        SIZE_RESET = 8'd100;

  localparam logic [1:0] FUNC_ADD   = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [0:0] REG_SIZE = 1'b0;

  typedef struct packed {
    logic exec;
    logic div_fin;
    logic rd_fin;
    logic load;
  } rs_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       append;
    logic       div_done;
    logic       out_free;
  } rs_stat_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [7:0] v);
    logic [SIZE_W-1:0] res;
    if (v == 8'd0) begin
      res = SIZE_W'(1);
    end else if (32'(v) > DEPTH) begin
      res = SIZE_W'(DEPTH);
    end else begin
      res = SIZE_W'(v);
    end
    return res;
  endfunction

endpackage

@@ src/reservoir_sampler.sv @@
// Top level of the reservoir sampler (Algorithm R over 64-bit samples).
// Depends on rs_pkg, rs_ctrl, rs_datapath (and rs_div below it).
//
//   channel  dir  handshake                  payload
//   in_      in   in_tvalid / in_tready      in_tuser func, in_tdata sample/random/index
//   out_     out  out_tvalid / out_tready    out_tdata result fields
//   cfg_     in   APB psel/penable/pready    reservoir_size at byte address 0
//
// Append, clear, unused code: decode, then result state loads the result register; read: decode, read, result.
// Replacing add: decode, then divide until the 32-step radix-2 remainder unit is done, then result.
// One item in flight; the next is taken once its result sits in the output register.
// Synchronous active-low reset; size returns to 100, store empty.
// A stalled output holds the result and the item behind it waits in the sequencer.
module reservoir_sampler (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [103:0]  in_tdata,   // sample_value[63:0], random_word[95:64], read_index[102:96]
  input  logic [1:0]    in_tuser,   // func[1:0]
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [111:0]  out_tdata,  // stored[0], slot[7:1], fill_level[15:8], processed[46:16],
                                    // read_data[110:47], read_valid[111]
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [2:0]    cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  output logic [31:0]   cfg_prdata,
  output logic          cfg_pready
);

  rs_pkg::rs_cmd_t  cmd;
  rs_pkg::rs_stat_t stat;
  logic             cfg_wr;
  logic [7:0]       size_rd;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[2] == rs_pkg::REG_SIZE);
  assign cfg_prdata = (cfg_paddr[2] == rs_pkg::REG_SIZE) ? {24'd0, size_rd} : 32'd0;

  rs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rs_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_load   (in_tvalid && in_tready),
    .in_func   (in_tuser),
    .in_sample (in_tdata[63:0]),
    .in_rand   (in_tdata[95:64]),
    .in_ridx   (in_tdata[102:96]),
    .cfg_wr    (cfg_wr),
    .cfg_data  (cfg_pwdata[7:0]),
    .size_rd   (size_rd),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

@@ src/rs_div.sv @@
// Radix-2 restoring divider, one quotient bit a cycle; returns the remainder.
// Depends on rs_pkg.
module rs_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rs_pkg::RND_W-1:0]    dividend,
  input  logic [rs_pkg::SEEN_W-1:0]   divisor,
  output logic                        done,
  output logic [rs_pkg::SEEN_W-1:0]   rem
);

  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [4:0]                cnt_r, cnt_nxt;
  logic [rs_pkg::RND_W-1:0]  dvd_r, dvd_nxt;
  logic [rs_pkg::RND_W-1:0]  rem_r, rem_nxt;
  logic [rs_pkg::SEEN_W-1:0] dvs_r, dvs_nxt;
  logic [rs_pkg::RND_W-1:0]  rem_sh;

  assign rem_sh = {rem_r[rs_pkg::RND_W-2:0], dvd_r[rs_pkg::RND_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[rs_pkg::RND_W-2:0], 1'b0};
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = rem_sh - {1'b0, dvs_r};
      end else begin
        rem_nxt = rem_sh;
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r[rs_pkg::SEEN_W-1:0];

endmodule

@@ src/rs_datapath.sv @@
// Sample store, counters, size register, divider and result register.
// Depends on rs_pkg, rs_div and reservoir_sampler_defines.svh.
`include "reservoir_sampler_defines.svh"

module rs_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rs_pkg::rs_cmd_t             cmd,
  output rs_pkg::rs_stat_t            stat,
  input  logic                        in_load,
  input  logic [1:0]                  in_func,
  input  logic [rs_pkg::SMP_W-1:0]    in_sample,
  input  logic [rs_pkg::RND_W-1:0]    in_rand,
  input  logic [6:0]                  in_ridx,
  input  logic                        cfg_wr,
  input  logic [7:0]                  cfg_data,
  output logic [7:0]                  size_rd,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [111:0]                out_data
);

  logic [1:0]                func_r;
  logic [rs_pkg::SMP_W-1:0]  sample_r;
  logic [rs_pkg::RND_W-1:0]  rand_r;
  logic [6:0]                ridx_r;

  logic [rs_pkg::SIZE_W-1:0] size_r, size_nxt;
  logic [rs_pkg::SIZE_W-1:0] fill_r, fill_nxt;
  logic [rs_pkg::SEEN_W-1:0] seen_r, seen_nxt, seen_inc;

  logic                      res_stored_r, res_stored_nxt;
  logic [6:0]                res_slot_r, res_slot_nxt;
  logic [rs_pkg::SMP_W-1:0]  res_rdata_r, res_rdata_nxt;
  logic                      res_rvalid_r, res_rvalid_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic [111:0]              out_data_r;

  logic [rs_pkg::SMP_W-1:0]  mem [rs_pkg::DEPTH];
  logic [rs_pkg::SMP_W-1:0]  rd_r;
  logic                      wr_en;
  logic [rs_pkg::ADDR_W-1:0] wr_addr;

  logic                      div_start, div_done;
  logic [rs_pkg::SEEN_W-1:0] div_rem;
  logic                      rem_hit;

  assign seen_inc = (seen_r == rs_pkg::SEEN_MAX) ? seen_r : seen_r + 1'b1;
  assign rem_hit  = div_rem < rs_pkg::SEEN_W'(size_r);

  rs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rand_r),
    .divisor  (seen_inc),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (in_load) begin
      func_r   <= in_func;
      sample_r <= in_sample;
      rand_r   <= in_rand;
      ridx_r   <= in_ridx;
    end
  end

  always_comb begin
    size_nxt       = size_r;
    fill_nxt       = fill_r;
    seen_nxt       = seen_r;
    res_stored_nxt = res_stored_r;
    res_slot_nxt   = res_slot_r;
    res_rdata_nxt  = res_rdata_r;
    res_rvalid_nxt = res_rvalid_r;
    wr_en          = 1'b0;
    wr_addr        = fill_r[rs_pkg::ADDR_W-1:0];
    div_start      = 1'b0;

    if (cfg_wr) begin
      size_nxt = rs_pkg::clamp_size(cfg_data);
      fill_nxt = '0;
      seen_nxt = '0;
    end

    if (cmd.exec) begin
      res_stored_nxt = 1'b0;
      res_slot_nxt   = '0;
      res_rdata_nxt  = '0;
      res_rvalid_nxt = 1'b0;
      unique case (func_r)
        rs_pkg::FUNC_ADD: begin
          seen_nxt = seen_inc;
          if (fill_r < size_r) begin
            wr_en          = 1'b1;
            fill_nxt       = fill_r + 1'b1;
            res_stored_nxt = 1'b1;
            res_slot_nxt   = 7'(fill_r);
          end else begin
            div_start = 1'b1;
          end
        end
        rs_pkg::FUNC_READ: begin
          res_rvalid_nxt = rs_pkg::SIZE_W'(ridx_r) < fill_r;
        end
        rs_pkg::FUNC_CLEAR: begin
          fill_nxt = '0;
          seen_nxt = '0;
        end
        default: begin
        end
      endcase
    end

    if (cmd.div_fin && rem_hit) begin
      wr_en          = 1'b1;
      wr_addr        = div_rem[rs_pkg::ADDR_W-1:0];
      res_stored_nxt = 1'b1;
      res_slot_nxt   = 7'(div_rem);
    end

    if (cmd.rd_fin) begin
      res_rdata_nxt = res_rvalid_r ? rd_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= sample_r;
    end
    rd_r <= mem[ridx_r[rs_pkg::ADDR_W-1:0]];
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r      <= rs_pkg::clamp_size(rs_pkg::SIZE_RESET);
      fill_r      <= '0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      size_r      <= size_nxt;
      fill_r      <= fill_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
    res_stored_r <= res_stored_nxt;
    res_slot_r   <= res_slot_nxt;
    res_rdata_r  <= res_rdata_nxt;
    res_rvalid_r <= res_rvalid_nxt;
    if (cmd.load) begin
      out_data_r <= {res_rvalid_r, res_rdata_r, seen_r, 8'(fill_r), res_slot_r, res_stored_r};
    end
  end

  assign stat.func     = func_r;
  assign stat.append   = fill_r < size_r;
  assign stat.div_done = div_done;
  assign stat.out_free = !out_valid_r || out_ready;

  assign size_rd   = 8'(size_r);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `RS_ASSERT(a_fill_le_size, clk, rst_n, fill_r <= size_r)
  `RS_ASSERT(a_size_range, clk, rst_n, size_r != '0 && 32'(size_r) <= rs_pkg::DEPTH)
  `RS_ASSERT(a_div_rem, clk, rst_n, div_done |-> div_rem < seen_r)
  `RS_ASSERT(a_write_full, clk, rst_n, cmd.div_fin |-> fill_r == size_r)

endmodule

@@ src/rs_ctrl.sv @@
// Sequencer for the reservoir sampler: steps one item through decode,
// divide or read where needed, and result hand-off. Depends on rs_pkg.
module rs_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  rs_pkg::rs_stat_t stat,
  output rs_pkg::rs_cmd_t  cmd
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DECODE = 5'b00010,
    ST_DIVIDE = 5'b00100,
    ST_READ   = 5'b01000,
    ST_RESULT = 5'b10000
  } state_t;

  state_t st_r, st_nxt;

  always_comb begin
    st_nxt      = st_r;
    cmd.exec    = 1'b0;
    cmd.div_fin = 1'b0;
    cmd.rd_fin  = 1'b0;
    cmd.load    = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          st_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.exec = 1'b1;
        if (stat.func == rs_pkg::FUNC_ADD && !stat.append) begin
          st_nxt = ST_DIVIDE;
        end else if (stat.func == rs_pkg::FUNC_READ) begin
          st_nxt = ST_READ;
        end else begin
          st_nxt = ST_RESULT;
        end
      end
      ST_DIVIDE: begin
        if (stat.div_done) begin
          cmd.div_fin = 1'b1;
          st_nxt      = ST_RESULT;
        end
      end
      ST_READ: begin
        cmd.rd_fin = 1'b1;
        st_nxt     = ST_RESULT;
      end
      ST_RESULT: begin
        if (stat.out_free) begin
          cmd.load = 1'b1;
          st_nxt   = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign in_ready = (st_r == ST_IDLE);

endmodule
